### design/tdse_pkg.sv
// Shared types and constants of the dictionary symbol expander.
// No dependencies; every other design file refers to this package.
package tdse_pkg;

  localparam int MODE_W = 2;
  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int OFFS_W = 12;
  localparam int CODE_W = 8;

  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;

  typedef struct packed {
    logic st_we;
    logic st_re;
    logic of_we;
    logic of_re;
  } mem_ctl_t;

endpackage

### design/tdse_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on tdse_pkg for the field widths.
interface tdse_in_if;
  logic                          valid;
  logic                          ready;
  logic [tdse_pkg::MODE_W-1:0]   mode;
  logic [tdse_pkg::ADDR_W-1:0]   load_address;
  logic [tdse_pkg::BYTE_W-1:0]   data_byte;
  logic [tdse_pkg::OFFS_W-1:0]   offset_value;

  modport source (output valid, mode, load_address, data_byte, offset_value, input ready);
  modport sink (input valid, mode, load_address, data_byte, offset_value, output ready);
endinterface

interface tdse_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdse_pkg::BYTE_W-1:0] out_char;
  logic                        last_of_symbol;
  logic                        no_char;
  logic                        token_truncated;

  modport source (output valid, out_char, last_of_symbol, no_char, token_truncated,
                  input ready);
  modport sink (input valid, out_char, last_of_symbol, no_char, token_truncated,
                output ready);
endinterface

### design/tdse_mem.sv
// Token byte store and token offset table, each with one write and one
// registered read port. Depends on tdse_pkg for the control struct.
module tdse_mem #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  tdse_pkg::mem_ctl_t             ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0] st_waddr,
  input  logic [tdse_pkg::BYTE_W-1:0]    st_wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0] st_raddr,
  output logic [tdse_pkg::BYTE_W-1:0]    st_rdata,
  input  logic [tdse_pkg::CODE_W-1:0]    of_waddr,
  input  logic [tdse_pkg::OFFS_W-1:0]    of_wdata,
  input  logic [tdse_pkg::CODE_W-1:0]    of_raddr,
  output logic [tdse_pkg::OFFS_W-1:0]    of_rdata
);

  localparam int NCODES = 1 << tdse_pkg::CODE_W;

  logic [tdse_pkg::BYTE_W-1:0] store [TABLE_DEPTH];
  logic [tdse_pkg::OFFS_W-1:0] offsets [NCODES];

  always_ff @(posedge clk) begin
    if (ctl.st_we) begin
      store[st_waddr] <= st_wdata;
    end
    if (ctl.st_re) begin
      st_rdata <= store[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.of_we) begin
      offsets[of_waddr] <= of_wdata;
    end
    if (ctl.of_re) begin
      of_rdata <= offsets[of_raddr];
    end
  end

endmodule

### design/tdse_seq.sv
// Sequencer: symbol framing, offset reduction, token scan and character
// output. Depends on tdse_pkg and the channel interfaces in tdse_if.sv.
module tdse_seq #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  tdse_in_if.sink                        cmd,
  tdse_out_if.source                     res,
  output tdse_pkg::mem_ctl_t             ctl,
  output logic [$clog2(TABLE_DEPTH)-1:0] st_waddr,
  output logic [tdse_pkg::BYTE_W-1:0]    st_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] st_raddr,
  input  logic [tdse_pkg::BYTE_W-1:0]    st_rdata,
  output logic [tdse_pkg::CODE_W-1:0]    of_waddr,
  output logic [tdse_pkg::OFFS_W-1:0]    of_wdata,
  output logic [tdse_pkg::CODE_W-1:0]    of_raddr,
  input  logic [tdse_pkg::OFFS_W-1:0]    of_rdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = (AW > tdse_pkg::OFFS_W) ? AW : tdse_pkg::OFFS_W;
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SETUP = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EWR   = 3'd6;
  localparam logic [2:0] S_MARK  = 3'd7;

  logic [2:0]                  state;
  logic [tdse_pkg::CODE_W-1:0] codes_left;
  logic                        awaiting_length;
  logic                        first_dropped;
  logic                        final_code;
  logic                        trunc;
  logic                        pend;
  logic [PW-1:0]               pos;
  logic [AW-1:0]               rpos;
  logic [LW-1:0]               len;
  logic [LW-1:0]               cnt;
  logic                        out_valid;
  logic [tdse_pkg::BYTE_W-1:0] out_char;
  logic                        out_last;
  logic                        out_none;
  logic                        out_trunc;

  logic          accept;
  logic          out_free;
  logic          load_char;
  logic          load_mark;
  logic [AW-1:0] rpos_inc;
  logic [AW-1:0] base_inc;
  logic          skip;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || res.ready;
  assign load_char = (state == S_EWR) && out_free;
  assign load_mark = (state == S_MARK) && out_free;
  assign rpos_inc  = wrap_inc(rpos);
  assign base_inc  = wrap_inc(pos[AW-1:0]);
  assign skip      = (len != '0) && !first_dropped;

  always_comb begin
    ctl.st_we = accept && (cmd.mode == tdse_pkg::MODE_STORE)
                && (32'(cmd.load_address) < TABLE_DEPTH);
    ctl.of_we = accept && (cmd.mode == tdse_pkg::MODE_OFFSET)
                && (cmd.load_address[tdse_pkg::ADDR_W-1:tdse_pkg::CODE_W] == '0);
    ctl.of_re = accept && (cmd.mode == tdse_pkg::MODE_STREAM) && !awaiting_length;
    ctl.st_re = (state == S_SCAN) || (state == S_ERD);
  end

  assign st_waddr = AW'(cmd.load_address);
  assign st_wdata = cmd.data_byte;
  assign st_raddr = rpos;
  assign of_waddr = cmd.load_address[tdse_pkg::CODE_W-1:0];
  assign of_wdata = cmd.offset_value;
  assign of_raddr = cmd.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      codes_left      <= '0;
      awaiting_length <= 1'b1;
      first_dropped   <= 1'b0;
      final_code      <= 1'b0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (load_char || load_mark) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (cmd.mode == tdse_pkg::MODE_STREAM)) begin
            if (awaiting_length) begin
              first_dropped <= 1'b0;
              codes_left    <= cmd.data_byte;
              if (cmd.data_byte == '0) begin
                state <= S_MARK;
              end else begin
                awaiting_length <= 1'b0;
              end
            end else begin
              codes_left <= codes_left - 1'b1;
              final_code <= (codes_left == tdse_pkg::CODE_W'(1));
              if (codes_left == tdse_pkg::CODE_W'(1)) begin
                awaiting_length <= 1'b1;
              end
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          pos   <= PW'(of_rdata);
          state <= S_MOD;
        end
        S_MOD: begin
          if (32'(pos) >= TABLE_DEPTH) begin
            pos <= pos - PW'(TABLE_DEPTH);
          end else begin
            rpos  <= pos[AW-1:0];
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rpos <= rpos_inc;
          pend <= 1'b1;
          if (pend) begin
            if (st_rdata == '0) begin
              len   <= cnt;
              trunc <= 1'b0;
              pend  <= 1'b0;
              state <= S_SETUP;
            end else if (cnt == LW'(MAX_TOKEN_LEN - 1)) begin
              len   <= LW'(MAX_TOKEN_LEN);
              trunc <= 1'b1;
              pend  <= 1'b0;
              state <= S_SETUP;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_SETUP: begin
          if (skip) begin
            first_dropped <= 1'b1;
            rpos          <= base_inc;
            cnt           <= len - 1'b1;
          end else begin
            rpos <= pos[AW-1:0];
            cnt  <= len;
          end
          if ((len == '0) || (skip && (len == LW'(1)))) begin
            state <= final_code ? S_MARK : S_IDLE;
          end else begin
            state <= S_ERD;
          end
        end
        S_ERD: begin
          rpos  <= rpos_inc;
          state <= S_EWR;
        end
        S_EWR: begin
          if (out_free) begin
            cnt   <= cnt - 1'b1;
            state <= (cnt == LW'(1)) ? S_IDLE : S_ERD;
          end
        end
        S_MARK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_char) begin
      out_char  <= st_rdata;
      out_last  <= final_code && (cnt == LW'(1));
      out_none  <= 1'b0;
      out_trunc <= trunc;
    end else if (load_mark) begin
      out_char  <= '0;
      out_last  <= 1'b1;
      out_none  <= 1'b1;
      out_trunc <= 1'b0;
    end
  end

  assign res.valid           = out_valid;
  assign res.out_char        = out_char;
  assign res.last_of_symbol  = out_last;
  assign res.no_char         = out_none;
  assign res.token_truncated = out_trunc;

  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (awaiting_length == (codes_left == '0)))
    else $error("symbol framing and code count disagree");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EWR || state == S_ERD) |-> (cnt != '0))
    else $error("character output with no characters left");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(cnt) < MAX_TOKEN_LEN))
    else $error("token scan ran past its length cap");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    ctl.st_re |-> (32'(rpos) < TABLE_DEPTH))
    else $error("store read address beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_char || load_mark) && out_valid |-> res.ready)
    else $error("result word replaced before it was taken");

endmodule

### design/token_dictionary_symbol_expander.sv
// Top level of the dictionary symbol expander: sequencer plus token memories.
// Depends on tdse_pkg, tdse_if.sv, tdse_mem and tdse_seq.
//
//   channel  dir  fields                                             handshake
//   cmd      in   mode, load_address, data_byte, offset_value        valid/ready
//   res      out  out_char, last_of_symbol, no_char, token_truncated valid/ready
//
// Load words and length bytes are taken while the sequencer is idle; a zero
// length also sends a marker word. A code byte goes through the offset lookup,
// repeated subtraction of TABLE_DEPTH while the offset is at or above it, the
// scan of its token up to the zero byte or the MAX_TOKEN_LEN cap, a setup step,
// a store read and an output step per character sent, and an end marker when
// the final code of a symbol sends no character. A stalled result side holds
// the sequencer in its output step. Reset clears the framing and control state
// only; both memories are undefined until loaded.
module token_dictionary_symbol_expander #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  tdse_in_if.sink     cmd,
  tdse_out_if.source  res
);

  localparam int AW = $clog2(TABLE_DEPTH);

  tdse_pkg::mem_ctl_t          ctl;
  logic [AW-1:0]               st_waddr;
  logic [tdse_pkg::BYTE_W-1:0] st_wdata;
  logic [AW-1:0]               st_raddr;
  logic [tdse_pkg::BYTE_W-1:0] st_rdata;
  logic [tdse_pkg::CODE_W-1:0] of_waddr;
  logic [tdse_pkg::OFFS_W-1:0] of_wdata;
  logic [tdse_pkg::CODE_W-1:0] of_raddr;
  logic [tdse_pkg::OFFS_W-1:0] of_rdata;

  tdse_seq #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .ctl      (ctl),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .of_waddr (of_waddr),
    .of_wdata (of_wdata),
    .of_raddr (of_raddr),
    .of_rdata (of_rdata)
  );

  tdse_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .ctl      (ctl),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .of_waddr (of_waddr),
    .of_wdata (of_wdata),
    .of_raddr (of_raddr),
    .of_rdata (of_rdata)
  );

endmodule
